FILE: rtl/core/rmid_pkg.sv
// Shared types, constants and codes for the ring minimum-image distance block.
package rmid_pkg;

    // Field widths fixed by the interface.
    localparam int IDX_W   = 5;   // particle and partner index
    localparam int NUM_W   = 6;   // num_particles register
    localparam int POS_W   = 31;  // stored position, unsigned Q15.16
    localparam int COORD_W = 32;  // signed coordinate and displacement
    localparam int SQ_W    = 62;  // squared distance, Q30.32
    localparam int ACC_W   = 33;  // signed working width of the shared adder
    localparam int STAT_W  = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_LENGTH   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PARTICLES = 1'd1;

    // Register reset values.
    localparam logic [POS_W-1:0] RING_LENGTH_RST   = 31'd65536;
    localparam logic [NUM_W-1:0] NUM_PARTICLES_RST = 6'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_PAIR       = 2'd0;
    localparam logic [STAT_W-1:0] ST_OFF_RING   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_PARTNER = 2'd2;

    typedef logic signed [ACC_W-1:0] t_acc;

endpackage

FILE: rtl/core/rmid_alu.sv
// Shared add/subtract unit used for wrapping, differences and folding.
module rmid_alu
    import rmid_pkg::*;
(
    input  t_acc i_a,
    input  t_acc i_b,
    input  logic i_sub,
    output t_acc o_sum
);

    // One adder: subtraction adds the inverted operand plus one.
    always_comb begin
        o_sum = i_a + (i_sub ? ~i_b : i_b) + t_acc'(i_sub);
    end

endmodule

FILE: rtl/core/rmid_posmem.sv
// Particle position memory with per-entry valid bits that read as zero after reset.
module rmid_posmem
    import rmid_pkg::*;
#(
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [POS_W-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [POS_W-1:0] o_rdata
);

    logic [POS_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [POS_W-1:0] r_rdata;
    logic             r_rd_valid;

    // Storage array and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    // Valid bits are cleared at reset so unwritten entries read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rd_valid ? r_rdata : '0;

endmodule

FILE: rtl/core/ring_min_image_distances_core.sv
// Ring minimum-image distance block: top level with sequencer and result register.
//
// Usage: a word on the input channel (i_in_valid / o_in_stall) moves one
// particle to i_new_position, signed Q15.16. The block wraps the coordinate
// onto the ring by repeated subtraction or addition of ring_length, one
// correction per cycle, and stores it. It then walks every other particle in
// use in ascending order and emits one result word per partner on the output
// channel (o_out_valid / i_out_stall), o_last marking the final word. An
// index not in use, a lone particle, more than MAX_WRAPS corrections, or a
// zero ring_length with a nonzero coordinate give a single word with a
// nonzero status instead. Each partner passes through the shared adder,
// the absolute value and the squaring multiplier. The input stays stalled
// from when an item is taken until its last word enters the output
// register, including while the receiver stalls.
// The output word sits in its own register, so the next input word is taken
// while the last result of the previous one still waits. A stalled receiver
// holds the sequencer at its output step and the word stays unchanged.
// Reset returns ring_length to 1.0, num_particles to 2, and all stored
// positions read as zero. Configuration must be written through i_cfg_we
// only while idle; the block itself does not enforce this.
module ring_min_image_distances_core
    import rmid_pkg::*;
#(
    parameter int MAX_PARTICLES = 32,
    parameter int MAX_WRAPS     = 5000
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [IDX_W-1:0]         i_particle_index,
    input  logic signed [COORD_W-1:0] i_new_position,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [STAT_W-1:0]        o_status,
    output logic [IDX_W-1:0]         o_partner_index,
    output logic signed [COORD_W-1:0] o_displacement,
    output logic [POS_W-1:0]         o_distance,
    output logic [SQ_W-1:0]          o_distance_squared,
    output logic                     o_last
);

    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CW = $clog2(MAX_PARTICLES + 1);
    localparam int WW = $clog2(MAX_WRAPS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WRAP  = 3'd1;
    localparam logic [2:0] S_STORE = 3'd2;
    localparam logic [2:0] S_NEXT  = 3'd3;
    localparam logic [2:0] S_DIFF  = 3'd4;
    localparam logic [2:0] S_FOLD  = 3'd5;
    localparam logic [2:0] S_ABS   = 3'd6;
    localparam logic [2:0] S_SQ    = 3'd7;

    // Sequencer and datapath registers.
    logic [2:0]         r_state, n_state;
    logic               r_emit, n_emit;
    logic [POS_W-1:0]   r_len;
    logic [NUM_W-1:0]   r_num;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_j, n_j;
    logic [WW-1:0]      r_wraps, n_wraps;
    t_acc               r_x, n_x;
    t_acc               r_d, n_d;
    logic [POS_W-1:0]   r_mag, n_mag;
    logic [SQ_W-1:0]    r_sq, n_sq;
    logic [STAT_W-1:0]  r_status, n_status;
    logic               r_last, n_last;

    // Output register.
    logic               r_out_valid;
    logic [STAT_W-1:0]  r_o_status;
    logic [IDX_W-1:0]   r_o_partner;
    logic [COORD_W-1:0] r_o_disp;
    logic [POS_W-1:0]   r_o_dist;
    logic [SQ_W-1:0]    r_o_sq;
    logic               r_o_last;

    logic               in_acc;
    logic               out_free;
    logic [CW-1:0]      count_lim;
    t_acc               alu_a, alu_b, alu_sum;
    logic               alu_sub;
    t_acc               len_acc;
    t_acc               mem_acc;
    logic [POS_W-1:0]   mem_rdata;
    logic               mem_we;
    logic signed [ACC_W:0] d2, len2;
    logic               fold_gt, fold_lt;
    t_acc               mag_full;
    logic               j_lt_idx, j_is_idx, after_last;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign len_acc  = t_acc'({2'b00, r_len});
    assign mem_acc  = t_acc'({2'b00, mem_rdata});
    assign mem_we   = (r_state == S_STORE) && !r_emit;

    // Particles in use, limited to the memory depth.
    assign count_lim = (32'(r_num) > MAX_PARTICLES) ? CW'(MAX_PARTICLES) : CW'(r_num);

    // Partner order helpers.
    assign j_lt_idx   = 32'(r_j) < 32'(r_idx);
    assign j_is_idx   = 32'(r_j) == 32'(r_idx);
    assign after_last = (32'(r_j) + 32'd1 == 32'(r_count))
                     || ((32'(r_j) + 32'd1 == 32'(r_idx))
                         && (32'(r_j) + 32'd2 == 32'(r_count)));

    // Fold test: compare twice the displacement with the ring length.
    assign d2      = {r_d, 1'b0};
    assign len2    = (ACC_W + 1)'(signed'({2'b00, r_len}));
    assign fold_gt = d2 > len2;
    assign fold_lt = d2 < -len2;
    assign mag_full = r_d[ACC_W-1] ? -r_d : r_d;

    // Operand selection for the shared adder.
    always_comb begin
        alu_a   = r_x;
        alu_b   = len_acc;
        alu_sub = 1'b1;
        case (r_state)
            S_WRAP: begin
                alu_a   = r_x;
                alu_b   = len_acc;
                alu_sub = !r_x[ACC_W-1];
            end
            S_DIFF: begin
                alu_a   = j_lt_idx ? mem_acc : r_x;
                alu_b   = j_lt_idx ? r_x : mem_acc;
                alu_sub = 1'b1;
            end
            S_FOLD: begin
                alu_a   = r_d;
                alu_b   = len_acc;
                alu_sub = fold_gt;
            end
            default: begin
                alu_a   = r_x;
                alu_b   = len_acc;
                alu_sub = 1'b1;
            end
        endcase
    end

    rmid_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_sum (alu_sum)
    );

    rmid_posmem #(
        .DEPTH (MAX_PARTICLES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (AW'(r_idx)),
        .i_wdata (r_x[POS_W-1:0]),
        .i_raddr (r_j[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // Sequencer next-state logic.
    always_comb begin
        n_state  = r_state;
        n_emit   = r_emit;
        n_idx    = r_idx;
        n_count  = r_count;
        n_j      = r_j;
        n_wraps  = r_wraps;
        n_x      = r_x;
        n_d      = r_d;
        n_mag    = r_mag;
        n_sq     = r_sq;
        n_status = r_status;
        n_last   = r_last;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_idx   = i_particle_index;
                    n_count = count_lim;
                    n_x     = t_acc'(i_new_position);
                    n_wraps = '0;
                    n_j     = '0;
                    if (32'(i_particle_index) >= 32'(count_lim)) begin
                        n_status = ST_NO_PARTNER;
                        n_last   = 1'b1;
                        n_emit   = 1'b1;
                        n_state  = S_STORE;
                    end else begin
                        n_state = S_WRAP;
                    end
                end
            end
            S_WRAP: begin
                // One correction per cycle until the coordinate lies on the ring.
                if (r_len == '0) begin
                    if (r_x != '0) begin
                        n_status = ST_OFF_RING;
                        n_last   = 1'b1;
                        n_emit   = 1'b1;
                    end
                    n_state = S_STORE;
                end else if (r_x[ACC_W-1] || (!alu_sum[ACC_W-1] && alu_sum != '0)) begin
                    if (r_wraps == WW'(MAX_WRAPS)) begin
                        n_status = ST_OFF_RING;
                        n_last   = 1'b1;
                        n_emit   = 1'b1;
                        n_state  = S_STORE;
                    end else begin
                        n_x     = alu_sum;
                        n_wraps = r_wraps + 1'b1;
                    end
                end else begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                // Position is written here unless a single word is pending.
                if (r_emit) begin
                    if (out_free) begin
                        n_emit  = 1'b0;
                        n_state = S_IDLE;
                    end
                end else if (32'(r_count) < 32'd2) begin
                    n_status = ST_NO_PARTNER;
                    n_last   = 1'b1;
                    n_emit   = 1'b1;
                end else begin
                    n_status = ST_PAIR;
                    n_state  = S_NEXT;
                end
            end
            S_NEXT: begin
                if (j_is_idx) begin
                    n_j = r_j + 1'b1;
                end else begin
                    n_last  = after_last;
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                n_d     = alu_sum;
                n_state = S_FOLD;
            end
            S_FOLD: begin
                if (fold_gt || fold_lt) begin
                    n_d = alu_sum;
                end
                n_state = S_ABS;
            end
            S_ABS: begin
                n_mag   = mag_full[POS_W-1:0];
                n_state = S_SQ;
            end
            S_SQ: begin
                // Square is computed once and held until the word is taken.
                if (!r_emit) begin
                    n_sq   = SQ_W'(r_mag) * SQ_W'(r_mag);
                    n_emit = 1'b1;
                end else if (out_free) begin
                    n_emit = 1'b0;
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = S_NEXT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_emit  <= 1'b0;
            r_len   <= RING_LENGTH_RST;
            r_num   <= NUM_PARTICLES_RST;
        end else begin
            r_state <= n_state;
            r_emit  <= n_emit;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RING_LENGTH:   r_len <= i_cfg_data[POS_W-1:0];
                    CFG_NUM_PARTICLES: r_num <= i_cfg_data[NUM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_count  <= n_count;
        r_j      <= n_j;
        r_wraps  <= n_wraps;
        r_x      <= n_x;
        r_d      <= n_d;
        r_mag    <= n_mag;
        r_sq     <= n_sq;
        r_status <= n_status;
        r_last   <= n_last;
    end

    // Output word register; error words carry zero payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_emit && out_free && (r_state == S_STORE || r_state == S_SQ)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_emit && out_free && (r_state == S_STORE || r_state == S_SQ)) begin
            r_o_status <= r_status;
            r_o_last   <= r_last;
            if (r_state == S_SQ) begin
                r_o_partner <= r_j[IDX_W-1:0];
                r_o_disp    <= r_d[COORD_W-1:0];
                r_o_dist    <= r_mag;
                r_o_sq      <= r_sq;
            end else begin
                r_o_partner <= '0;
                r_o_disp    <= '0;
                r_o_dist    <= '0;
                r_o_sq      <= '0;
            end
        end
    end

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_status           = r_o_status;
    assign o_partner_index    = r_o_partner;
    assign o_displacement     = r_o_disp;
    assign o_distance         = r_o_dist;
    assign o_distance_squared = r_o_sq;
    assign o_last             = r_o_last;

endmodule

FILE: rtl/core/rmid_checker.sv
// Port-level checks for the ring minimum-image distance block, with its bind.
module rmid_checker
    import rmid_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [STAT_W-1:0]         o_status,
    input logic [IDX_W-1:0]          o_partner_index,
    input logic signed [COORD_W-1:0] o_displacement,
    input logic [POS_W-1:0]          o_distance,
    input logic                      o_last
);

    logic [COORD_W-1:0] disp_mag;
    assign disp_mag = o_displacement[COORD_W-1] ? COORD_W'(-o_displacement)
                                                : COORD_W'(o_displacement);

    // A stalled output word stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    // The block is busy in the cycle after it takes a word.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again before the item was processed");

    // Error and no-partner words are single, final and carry zero payload.
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_PAIR |->
            o_last && o_partner_index == '0 && o_displacement == '0 && o_distance == '0)
        else $error("status word with nonzero payload or not final");

    // Distance is the magnitude of the displacement.
    a_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_PAIR |-> disp_mag == COORD_W'(o_distance))
        else $error("distance does not match displacement");

endmodule

bind ring_min_image_distances_core rmid_checker u_rmid_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_status        (o_status),
    .o_partner_index (o_partner_index),
    .o_displacement  (o_displacement),
    .o_distance      (o_distance),
    .o_last          (o_last)
);
